### sv/qbfp_pkg.sv
// Shared types, widths and register codes for the quadratic Bezier frame point block.
// Holds the restoring division step used by the front pipeline.
// No dependencies.
package qbfp_pkg;

    localparam int IDX_W     = 31;
    localparam int T_W       = 24;
    localparam int FPS_W     = 8;
    localparam int DUR_W     = 16;
    localparam int PERIOD_W  = FPS_W + DUR_W;
    localparam int COORD_W   = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 32;
    localparam int DIV_STEPS = IDX_W + T_W;
    localparam int WT_W      = 2 * T_W + 1;

    localparam logic [FPS_W-1:0] FPS_RESET = FPS_W'(30);
    localparam logic [DUR_W-1:0] DUR_RESET = DUR_W'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FPS,
        REG_DURATION,
        REG_START_RE,
        REG_START_IM,
        REG_MID_RE,
        REG_MID_IM,
        REG_END_RE,
        REG_END_IM
    } t_cfg_reg;

    typedef struct packed {
        logic [COORD_W-1:0] start_re;
        logic [COORD_W-1:0] start_im;
        logic [COORD_W-1:0] mid_re;
        logic [COORD_W-1:0] mid_im;
        logic [COORD_W-1:0] end_re;
        logic [COORD_W-1:0] end_im;
    } t_ctrl_pts;

    typedef struct packed {
        logic [PERIOD_W-1:0] rem;
        logic [IDX_W-1:0]    num;
        logic [T_W-1:0]      quo;
    } t_div_word;

    function automatic t_div_word div_step(t_div_word w_in, logic [PERIOD_W-1:0] period);
        logic [PERIOD_W:0] trial;
        logic [PERIOD_W:0] diff;
        t_div_word         w_out;
        trial     = {w_in.rem, w_in.num[IDX_W-1]};
        diff      = trial - {1'b0, period};
        w_out.num = {w_in.num[IDX_W-2:0], 1'b0};
        if (trial >= {1'b0, period}) begin
            w_out.rem = diff[PERIOD_W-1:0];
            w_out.quo = {w_in.quo[T_W-2:0], 1'b1};
        end else begin
            w_out.rem = trial[PERIOD_W-1:0];
            w_out.quo = {w_in.quo[T_W-2:0], 1'b0};
        end
        return w_out;
    endfunction

endpackage

### sv/quadratic_bezier_frame_point.sv
// Top level of the quadratic Bezier frame point block: configuration registers,
// front division pipeline, middle queue, back blend pipeline and result queue.
// Depends on qbfp_pkg, qbfp_fifo, qbfp_front and qbfp_back.
//
// Usage:
//   Input channel: a frame index is taken at a rising edge with push high and full low.
//   Result channel: while empty is low the oldest point is on o_point_real and
//   o_point_imag; it is taken at a rising edge with pop high.
//   Configuration: i_cfg_wr_en writes i_cfg_data to register i_cfg_index at once;
//   write only while no word is in flight.
//   Throughput: one word per cycle, sustained, when the result side pops every cycle.
//   Path: each index passes the 55-stage restoring divider that forms t one bit per
//   stage, then the middle queue, the back pipeline and the result queue.
//   Reset: registers return to 30 frames per second, 1 second and all points at zero;
//   both queues empty.
//   Stall: while pop is low the result queue fills, the back pipeline halts, the
//   middle queue fills, the front pipeline halts and full rises; nothing is dropped.
module quadratic_bezier_frame_point
    import qbfp_pkg::*;
#(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [IDX_W-1:0]     i_frame_index,
    output logic                 empty,
    input  logic                 pop,
    output logic [COORD_W-1:0]   o_point_real,
    output logic [COORD_W-1:0]   o_point_imag,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [FPS_W-1:0]      r_fps;
    logic [DUR_W-1:0]      r_dur;
    logic [PERIOD_W-1:0]   r_period;
    logic                  r_period_zero;
    t_ctrl_pts             r_pts;

    logic                  front_ready;
    logic                  front_valid;
    logic [T_W-1:0]        front_t;
    logic                  mid_full;
    logic                  mid_empty;
    logic [T_W-1:0]        mid_t;
    logic                  back_ready;
    logic                  back_valid;
    logic [COORD_W-1:0]    back_re;
    logic [COORD_W-1:0]    back_im;
    logic                  out_full;
    logic [2*COORD_W-1:0]  out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fps         <= FPS_RESET;
            r_dur         <= DUR_RESET;
            r_pts         <= '0;
            r_period      <= PERIOD_W'(FPS_RESET) * PERIOD_W'(DUR_RESET);
            r_period_zero <= 1'b0;
        end else begin
            r_period      <= PERIOD_W'(r_fps) * PERIOD_W'(r_dur);
            r_period_zero <= (r_fps == '0) || (r_dur == '0);
            if (i_cfg_wr_en) begin
                case (t_cfg_reg'(i_cfg_index))
                    REG_FPS:      r_fps        <= i_cfg_data[FPS_W-1:0];
                    REG_DURATION: r_dur        <= i_cfg_data[DUR_W-1:0];
                    REG_START_RE: r_pts.start_re <= i_cfg_data;
                    REG_START_IM: r_pts.start_im <= i_cfg_data;
                    REG_MID_RE:   r_pts.mid_re <= i_cfg_data;
                    REG_MID_IM:   r_pts.mid_im <= i_cfg_data;
                    REG_END_RE:   r_pts.end_re <= i_cfg_data;
                    REG_END_IM:   r_pts.end_im <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign full = !front_ready;

    qbfp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (push),
        .o_ready       (front_ready),
        .i_frame_index (i_frame_index),
        .i_period      (r_period),
        .i_period_zero (r_period_zero),
        .o_valid       (front_valid),
        .i_ready       (!mid_full),
        .o_t           (front_t)
    );

    qbfp_fifo #(
        .WIDTH (T_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_valid),
        .i_data  (front_t),
        .o_full  (mid_full),
        .i_pop   (back_ready),
        .o_data  (mid_t),
        .o_empty (mid_empty)
    );

    qbfp_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (!mid_empty),
        .o_ready      (back_ready),
        .i_t          (mid_t),
        .i_pts        (r_pts),
        .o_valid      (back_valid),
        .i_ready      (!out_full),
        .o_point_real (back_re),
        .o_point_imag (back_im)
    );

    qbfp_fifo #(
        .WIDTH (2 * COORD_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (back_valid),
        .i_data  ({back_re, back_im}),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (out_word),
        .o_empty (empty)
    );

    assign o_point_real = out_word[2*COORD_W-1:COORD_W];
    assign o_point_imag = out_word[COORD_W-1:0];

endmodule

### sv/qbfp_fifo.sv
// Small first-in first-out word queue in flip-flops, head shown without delay.
// Used between the front and back pipelines and at the result side.
// No dependencies.
module qbfp_fifo #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr;
    logic             rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (wr) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({wr, rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr && !rd) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count did not advance on write");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rd && !wr && r_count == CNT_W'(1)) |=> o_empty)
        else $error("queue not empty after last word read");
`endif

endmodule

### sv/qbfp_front.sv
// Front pipeline: takes frame indices and runs a one-bit-per-stage restoring division
// of the index, extended by the fraction bits, by the curve period to form t.
// Depends on qbfp_pkg.
module qbfp_front
    import qbfp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [IDX_W-1:0]    i_frame_index,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_period_zero,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [T_W-1:0]      o_t
);

    localparam int FST = DIV_STEPS + 1;

    logic [FST-1:0] r_v, n_v;
    t_div_word      r_w [FST];
    t_div_word      n_w [FST];
    t_div_word      seed;
    logic           en;

    assign en      = !r_v[FST-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_v[FST-1];
    assign o_t     = i_period_zero ? '0 : r_w[FST-1].quo;

    always_comb begin
        seed.rem = '0;
        seed.num = i_frame_index;
        seed.quo = '0;
        n_v      = {r_v[FST-2:0], i_valid};
        n_w[0]   = seed;
        for (int s = 1; s < FST; s++) begin
            n_w[s] = div_step(r_w[s-1], i_period);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= n_w;
        end
    end

`ifndef SYNTHESIS
    a_hold_t: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[FST-1] && !i_ready) |=> (r_v[FST-1] && $stable(r_w[FST-1].quo)))
        else $error("front output word changed while stalled");
`endif

endmodule

### sv/qbfp_back.sv
// Back pipeline: forms the three Bernstein weights from t, blends the biased control
// coordinates with split partial products, rounds and saturates both coordinates.
// Depends on qbfp_pkg.
module qbfp_back
    import qbfp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [T_W-1:0]     i_t,
    input  t_ctrl_pts          i_pts,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [COORD_W-1:0] o_point_real,
    output logic [COORD_W-1:0] o_point_imag
);

    localparam int NB   = 5;
    localparam int PH_W = COORD_W + T_W + 1;
    localparam int PL_W = COORD_W + T_W;
    localparam int HI_W = PH_W + 2;
    localparam int LO_W = PL_W + 2;
    localparam int Q_W  = HI_W - T_W;
    localparam logic [LO_W-1:0] RND = LO_W'(1) << (2 * T_W - 1);

    logic [NB-1:0]      r_v, n_v;
    logic               en;
    logic [T_W-1:0]     r_t;
    logic [WT_W-1:0]    r_wt [3];
    logic [WT_W-1:0]    n_wt [3];
    logic [PH_W-1:0]    r_ph [2][3];
    logic [PH_W-1:0]    n_ph [2][3];
    logic [PL_W-1:0]    r_pl [2][3];
    logic [PL_W-1:0]    n_pl [2][3];
    logic [HI_W-1:0]    r_hi [2];
    logic [HI_W-1:0]    n_hi [2];
    logic [LO_W-1:0]    r_lo [2];
    logic [LO_W-1:0]    n_lo [2];
    logic [COORD_W-1:0] r_pt [2];
    logic [COORD_W-1:0] n_pt [2];
    logic [COORD_W-1:0] coord [2][3];
    logic [COORD_W-1:0] cb [2][3];

    assign en           = !r_v[NB-1] || i_ready;
    assign o_ready      = en;
    assign o_valid      = r_v[NB-1];
    assign o_point_real = r_pt[0];
    assign o_point_imag = r_pt[1];

    always_comb begin
        coord[0][0] = i_pts.start_re;
        coord[0][1] = i_pts.mid_re;
        coord[0][2] = i_pts.end_re;
        coord[1][0] = i_pts.start_im;
        coord[1][1] = i_pts.mid_im;
        coord[1][2] = i_pts.end_im;
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
                cb[a][k] = {~coord[a][k][COORD_W-1], coord[a][k][COORD_W-2:0]};
            end
        end
    end

    always_comb begin
        logic [T_W:0]       u;
        logic [2*T_W+1:0]   uu;
        logic [2*T_W:0]     tu;
        logic [2*T_W-1:0]   tt;
        u       = {1'b1, {T_W{1'b0}}} - {1'b0, r_t};
        uu      = u * u;
        tu      = r_t * u;
        tt      = r_t * r_t;
        n_wt[0] = uu[WT_W-1:0];
        n_wt[1] = {tu[WT_W-2:0], 1'b0};
        n_wt[2] = {1'b0, tt};
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            for (int k = 0; k < 3; k++) begin
                n_ph[a][k] = cb[a][k] * r_wt[k][WT_W-1:T_W];
                n_pl[a][k] = cb[a][k] * r_wt[k][T_W-1:0];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_hi[a] = HI_W'(r_ph[a][0]) + HI_W'(r_ph[a][1]) + HI_W'(r_ph[a][2]);
            n_lo[a] = LO_W'(r_pl[a][0]) + LO_W'(r_pl[a][1]) + LO_W'(r_pl[a][2]) + RND;
        end
    end

    always_comb begin
        logic [HI_W-1:0]    s;
        logic [Q_W-1:0]     q;
        logic [COORD_W-1:0] r;
        for (int a = 0; a < 2; a++) begin
            s = r_hi[a] + HI_W'(r_lo[a] >> T_W);
            q = s[HI_W-1:T_W];
            if (|q[Q_W-1:COORD_W]) begin
                r = '1;
            end else begin
                r = q[COORD_W-1:0];
            end
            n_pt[a] = {~r[COORD_W-1], r[COORD_W-2:0]};
        end
    end

    assign n_v = {r_v[NB-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t  <= i_t;
            r_wt <= n_wt;
            r_ph <= n_ph;
            r_pl <= n_pl;
            r_hi <= n_hi;
            r_lo <= n_lo;
            r_pt <= n_pt;
        end
    end

`ifndef SYNTHESIS
    a_hold_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NB-1] && !i_ready) |=> (r_v[NB-1] && $stable(r_pt[0]) && $stable(r_pt[1])))
        else $error("back output word changed while stalled");
`endif

endmodule

### sim/quadratic_bezier_frame_point_tb.sv
// Self-checking testbench for quadratic_bezier_frame_point: streams frame indices under
// several curve settings and checks every point against a built-in blend predictor.
// Depends on qbfp_pkg and the quadratic_bezier_frame_point RTL.
`timescale 1ns / 100ps

module quadratic_bezier_frame_point_tb;
    import qbfp_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] point_real;
        logic [COORD_W-1:0] point_imag;
    } t_point;

    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int RANDOM_ROUNDS = 12;
    localparam int ROUND_FRAMES = 128;
    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam bit [63:0] T_ONE = 64'd1 << T_W;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 push = 1'b0;
    logic                 full;
    logic [IDX_W-1:0]     i_frame_index = '0;
    logic                 empty;
    logic                 pop = 1'b0;
    logic [COORD_W-1:0]   o_point_real;
    logic [COORD_W-1:0]   o_point_imag;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    logic [FPS_W-1:0] fps_cfg = FPS_RESET;
    logic [DUR_W-1:0] dur_cfg = DUR_RESET;
    t_ctrl_pts        pts_cfg = '0;

    logic [IDX_W-1:0] frame_backlog[$];
    t_point           curve_points[$];
    t_point           want;
    int               send_gap = 0;
    int               recv_gap = 0;
    int               gap_now;
    int               hold_left = 0;
    bit               hold_done = 1'b0;
    bit               pressure_on = 1'b0;
    int               send_idle_pct = 20;
    int               recv_idle_pct = 20;
    int               fail_count = 0;
    int               frames_sent = 0;
    int               zero_period_frames = 0;
    int               points_seen = 0;
    int               full_cycles = 0;
    int               curves_loaded = 0;

    quadratic_bezier_frame_point u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_frame_index (i_frame_index),
        .empty         (empty),
        .pop           (pop),
        .o_point_real  (o_point_real),
        .o_point_imag  (o_point_imag),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [COORD_W-1:0] blend_coord(
        input logic [COORD_W-1:0] c0, c1, c2,
        input bit [63:0] w0, w1, w2
    );
        bit [63:0] b0, b1, b2, hi, lo, q;
        b0 = 64'(c0 ^ COORD_MIN);
        b1 = 64'(c1 ^ COORD_MIN);
        b2 = 64'(c2 ^ COORD_MIN);
        hi = b0 * (w0 >> T_W) + b1 * (w1 >> T_W) + b2 * (w2 >> T_W);
        lo = b0 * (w0 & (T_ONE - 1)) + b1 * (w1 & (T_ONE - 1)) + b2 * (w2 & (T_ONE - 1));
        lo = lo + (64'd1 << 47);
        q = (hi + (lo >> T_W)) >> T_W;
        if (q > 64'hFFFF_FFFF)
            q = 64'hFFFF_FFFF;
        return q[COORD_W-1:0] ^ COORD_MIN;
    endfunction

    function automatic t_point bezier_point(input logic [IDX_W-1:0] idx);
        bit [63:0] period, x, t, u, w0, w1, w2;
        t_point    p;
        period = 64'(fps_cfg) * 64'(dur_cfg);
        t = 0;
        if (period != 0) begin
            x = 64'(idx) % period;
            t = ((x << T_W) / period) & (T_ONE - 1);
        end
        u = T_ONE - t;
        w0 = u * u;
        w1 = 2 * t * u;
        w2 = t * t;
        p.point_real = blend_coord(pts_cfg.start_re, pts_cfg.mid_re, pts_cfg.end_re, w0, w1, w2);
        p.point_imag = blend_coord(pts_cfg.start_im, pts_cfg.mid_im, pts_cfg.end_im, w0, w1, w2);
        return p;
    endfunction

    function automatic int pick_gap(input int pct);
        if ($urandom_range(0, 99) >= pct)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 60);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord();
        case ($urandom_range(0, 7))
            0: return COORD_MAX;
            1: return COORD_MIN;
            2: return '0;
            3: return COORD_W'($urandom_range(0, 32'h3_FFFF)) - 32'h2_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_frame();
        bit [63:0] period, base;
        period = 64'(fps_cfg) * 64'(dur_cfg);
        case ($urandom_range(0, 5))
            0: return '1;
            1: if (period != 0) begin
                base = 64'($urandom_range(0, 32'h7FFF_FFFF));
                base = base - base % period;
                case ($urandom_range(0, 2))
                    0: base = base;
                    1: base = base + 1;
                    default: base = base + period - 1;
                endcase
                if (base > 64'h7FFF_FFFF)
                    base = base - period;
                return base[IDX_W-1:0];
            end
            2: if (period != 0)
                return IDX_W'($urandom_range(0, 32'(period * 3)));
            default: ;
        endcase
        return IDX_W'($urandom);
    endfunction

    task automatic cfg_write(input t_cfg_reg sel, input logic [CFG_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= sel;
        i_cfg_data  <= data;
        case (sel)
            REG_FPS:      fps_cfg = data[FPS_W-1:0];
            REG_DURATION: dur_cfg = data[DUR_W-1:0];
            REG_START_RE: pts_cfg.start_re = data;
            REG_START_IM: pts_cfg.start_im = data;
            REG_MID_RE:   pts_cfg.mid_re = data;
            REG_MID_IM:   pts_cfg.mid_im = data;
            REG_END_RE:   pts_cfg.end_re = data;
            REG_END_IM:   pts_cfg.end_im = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic load_curve(
        input logic [CFG_W-1:0] fps_word,
        input logic [CFG_W-1:0] dur_word,
        input t_ctrl_pts p
    );
        cfg_write(REG_FPS, fps_word);
        cfg_write(REG_DURATION, dur_word);
        cfg_write(REG_START_RE, p.start_re);
        cfg_write(REG_START_IM, p.start_im);
        cfg_write(REG_MID_RE, p.mid_re);
        cfg_write(REG_MID_IM, p.mid_im);
        cfg_write(REG_END_RE, p.end_re);
        cfg_write(REG_END_IM, p.end_im);
        curves_loaded++;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (frame_backlog.size() != 0 || push || curve_points.size() != 0);
    endtask

    // offer frames from the backlog; hold the word while full
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap <= 0;
        end else begin
            if (push && full)
                full_cycles++;
            if (push && !full) begin
                curve_points.push_back(bezier_point(i_frame_index));
                frames_sent++;
                if (fps_cfg == 0 || dur_cfg == 0)
                    zero_period_frames++;
            end
            if (!push || !full) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    push <= 1'b0;
                end else if (frame_backlog.size() != 0) begin
                    push <= 1'b1;
                    i_frame_index <= frame_backlog.pop_front();
                    send_gap <= pick_gap(send_idle_pct);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // hold the receiver off once for a long stretch
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (pressure_on && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // take points and compare with the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            recv_gap <= 0;
        end else begin
            gap_now = recv_gap;
            if (pop && !empty) begin
                points_seen++;
                if (curve_points.size() == 0) begin
                    $error("unexpected point: point_real %h point_imag %h",
                           o_point_real, o_point_imag);
                    fail_count++;
                end else begin
                    want = curve_points.pop_front();
                    if (o_point_real !== want.point_real) begin
                        $error("point_real: expected %h, got %h", want.point_real, o_point_real);
                        fail_count++;
                    end
                    if (o_point_imag !== want.point_imag) begin
                        $error("point_imag: expected %h, got %h", want.point_imag, o_point_imag);
                        fail_count++;
                    end
                end
                gap_now = pick_gap(recv_idle_pct);
            end
            if ((pressure_on && !hold_done) || hold_left != 0) begin
                pop <= 1'b0;
            end else if (gap_now != 0) begin
                recv_gap <= gap_now - 1;
                pop <= 1'b0;
            end else begin
                recv_gap <= 0;
                pop <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        int               round;
        int               sel;
        logic [FPS_W-1:0] fps;
        logic [DUR_W-1:0] dur;
        logic [CFG_W-1:0] fps_word;
        logic [CFG_W-1:0] dur_word;
        t_ctrl_pts        p;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings
        frame_backlog.push_back(31'd0);
        frame_backlog.push_back(31'd15);
        frame_backlog.push_back(31'h7FFF_FFFF);
        wait_drained();

        load_curve(32'd30, 32'd1, {32'h0001_8000, 32'hFFFE_0000, COORD_MAX, COORD_MIN,
                                   COORD_MIN, COORD_MAX});
        frame_backlog.push_back(31'd0);
        frame_backlog.push_back(31'd1);
        frame_backlog.push_back(31'd29);
        frame_backlog.push_back(31'd30);
        frame_backlog.push_back(31'h5555_5555);
        frame_backlog.push_back(31'h2AAA_AAAA);
        wait_drained();

        // largest period, saturating corners
        load_curve(32'd255, 32'd65535, {COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN,
                                        COORD_MAX, COORD_MIN});
        frame_backlog.push_back(31'd16711424);
        frame_backlog.push_back(31'd16711425);
        frame_backlog.push_back(31'h7FFF_FFFF);
        frame_backlog.push_back(31'd8355712);
        wait_drained();

        // zero period from either factor
        load_curve(32'd0, 32'd7, {32'h1234_5678, 32'hFEDC_BA98, COORD_MAX, COORD_MIN,
                                  32'd0, 32'hFFFF_FFFF});
        frame_backlog.push_back(31'd0);
        frame_backlog.push_back(31'd12345);
        frame_backlog.push_back(31'h7FFF_FFFF);
        wait_drained();
        cfg_write(REG_FPS, 32'd60);
        cfg_write(REG_DURATION, 32'd0);
        @(negedge i_clk);
        frame_backlog.push_back(31'd77);
        frame_backlog.push_back(31'h4000_0000);
        wait_drained();

        // unit period
        load_curve(32'd1, 32'd1, {COORD_MIN, COORD_MAX, 32'd0, 32'd0, COORD_MAX, COORD_MIN});
        frame_backlog.push_back(31'd0);
        frame_backlog.push_back(31'd999);
        wait_drained();

        for (round = 0; round < RANDOM_ROUNDS; round++) begin
            wait_drained();
            sel = $urandom_range(0, 9);
            case (sel)
                0: begin
                    fps = '0;
                    dur = DUR_W'($urandom_range(1, 65535));
                end
                1: begin
                    fps = FPS_W'($urandom_range(1, 255));
                    dur = '0;
                end
                2: begin
                    fps = '1;
                    dur = '1;
                end
                3: begin
                    fps = FPS_W'(1);
                    dur = DUR_W'(1);
                end
                default: begin
                    fps = FPS_W'($urandom_range(1, 255));
                    dur = ($urandom_range(0, 3) == 0) ? DUR_W'($urandom_range(1, 65535))
                                                      : DUR_W'($urandom_range(1, 20));
                end
            endcase
            fps_word = $urandom;
            fps_word[FPS_W-1:0] = fps;
            dur_word = $urandom;
            dur_word[DUR_W-1:0] = dur;
            p = {pick_coord(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                 pick_coord()};
            load_curve(fps_word, dur_word, p);
            if (round == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                pressure_on = 1'b1;
            end else if (round == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = $urandom_range(5, 60);
                recv_idle_pct = $urandom_range(5, 60);
            end
            repeat (ROUND_FRAMES) frame_backlog.push_back(pick_frame());
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("%0d frame indices over %0d curve settings, %0d of them at zero period",
                 frames_sent, curves_loaded, zero_period_frames);
        $display("%0d points checked, input held off by full for %0d cycles",
                 points_seen, full_cycles);
        if (fail_count == 0)
            $display("quadratic_bezier_frame_point regression: pass");
        else
            $display("quadratic_bezier_frame_point regression: fail");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("quadratic_bezier_frame_point regression: fail");
        $finish;
    end

endmodule
